### sv/xorshift128_random_generator_core_macros.svh
// Assertion macros for the xorshift128 generator checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef XORSHIFT128_RANDOM_GENERATOR_CORE_MACROS_SVH
`define XORSHIFT128_RANDOM_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define XS_ASSERT_IMP(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication
`define XS_ASSERT_NXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

### sv/xs128_pkg.sv
// Shared types and constants for the xorshift128 generator.
// No dependencies.
package xs128_pkg;

  typedef struct packed {
    logic        operation;
    logic [31:0] seed_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] raw_word;
    logic [61:0] unit_real_bits;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED_ISSUE,
    ST_SEED_WAIT,
    ST_NORM
  } xs_state_t;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  localparam logic [31:0] SEED_MULT = 32'd1812433253;

  localparam logic [31:0] RST_WORD0 = 32'd123456789;
  localparam logic [31:0] RST_WORD1 = 32'd362436069;
  localparam logic [31:0] RST_WORD2 = 32'd521288629;
  localparam logic [31:0] RST_WORD3 = 32'd88675123;

  // biased exponent for a word with its leading one at bit 31 (2^-1)
  localparam logic [9:0] EXP_TOP = 10'd1022;

  // last step of the 16/8/4/2/1 leading-one search
  localparam logic [2:0] NORM_LAST = 3'd4;

endpackage

### sv/xs128_seed_mul.sv
// Shared seed multiplier: (x ^ x>>30) * SEED_MULT + k, registered.
// Depends on xs128_pkg.
module xs128_seed_mul (
  input  logic        clk,
  input  logic        issue,
  input  logic [31:0] x,
  input  logic [1:0]  k,
  output logic [31:0] res
);
  import xs128_pkg::*;

  logic [31:0] mix;
  logic [31:0] prod;
  logic [31:0] res_r;

  assign mix  = x ^ (x >> 30);
  assign prod = mix * SEED_MULT;

  always_ff @(posedge clk) begin
    if (issue) begin
      res_r <= prod + {30'd0, k};
    end
  end

  assign res = res_r;

endmodule

### sv/xs128_norm.sv
// Iterative leading-one normalizer: builds double bits of word / 2^32.
// Depends on xs128_pkg. One shift stage per cycle.
module xs128_norm (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] word,
  output logic        done,
  output logic [61:0] bits
);
  import xs128_pkg::*;

  logic [31:0] sh_r, sh_nxt;
  logic [4:0]  lz_r, lz_nxt;
  logic [2:0]  step_r;
  logic        busy_r;
  logic        done_r;

  // binary leading-zero search: 16, 8, 4, 2, 1
  always_comb begin
    sh_nxt = sh_r;
    lz_nxt = lz_r;
    case (step_r)
      3'd0: if (sh_r[31:16] == 16'd0) begin
        sh_nxt = {sh_r[15:0], 16'd0};
        lz_nxt = lz_r + 5'd16;
      end
      3'd1: if (sh_r[31:24] == 8'd0) begin
        sh_nxt = {sh_r[23:0], 8'd0};
        lz_nxt = lz_r + 5'd8;
      end
      3'd2: if (sh_r[31:28] == 4'd0) begin
        sh_nxt = {sh_r[27:0], 4'd0};
        lz_nxt = lz_r + 5'd4;
      end
      3'd3: if (sh_r[31:30] == 2'd0) begin
        sh_nxt = {sh_r[29:0], 2'd0};
        lz_nxt = lz_r + 5'd2;
      end
      3'd4: if (!sh_r[31]) begin
        sh_nxt = {sh_r[30:0], 1'b0};
        lz_nxt = lz_r + 5'd1;
      end
      default: begin
        sh_nxt = sh_r;
        lz_nxt = lz_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else if (busy_r) begin
      step_r <= step_r + 3'd1;
      if (step_r == NORM_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r <= word;
      lz_r <= 5'd0;
    end else if (busy_r) begin
      sh_r <= sh_nxt;
      lz_r <= lz_nxt;
    end
  end

  assign done = done_r;
  // exponent 1022 - lz, fraction is the word below its leading one
  assign bits = {EXP_TOP - {5'd0, lz_r}, sh_r[30:0], 21'd0};

endmodule

### sv/xorshift128_random_generator_core.sv
// Xorshift128 generator top level: sequencer, state words, output register.
// Depends on xs128_pkg, xs128_seed_mul, xs128_norm.
//
//  channel | ports                      | moves
//  --------+----------------------------+----------------------------------
//  input   | in_valid, in_stall, in_data | operation + seed_value word
//  output  | out_valid, out_stall, out_data | raw_word + unit_real_bits word
//
// A draw does one xorshift step at accept, then runs the leading-one
// normalizer, then loads the output register.
// A reseed runs four chained multiplies, each an issue state and a wait
// state, through the one shared multiplier. One word is in work at a time.
// Synchronous active-low reset loads the standard xorshift128 state words.
// A stalled output holds; the next word is still taken in, and a draw waits
// in the normalize state only until the output register frees up.
module xorshift128_random_generator_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xs128_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xs128_pkg::out_word_t out_data
);
  import xs128_pkg::*;

  xs_state_t   state_r, state_nxt;

  logic [31:0] words_r [4];
  logic [31:0] seed_r;
  logic [1:0]  k_r;
  logic [31:0] raw_r;
  logic        out_valid_r;
  out_word_t   out_r;

  logic        in_acc;
  logic        out_free;
  logic        norm_start;
  logic        norm_done;
  logic [61:0] norm_bits;
  logic        mul_issue;
  logic [31:0] mul_res;
  logic        out_load;

  logic [31:0] xs_t;
  logic [31:0] xs_w;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // one xorshift128 step from the current words
  assign xs_t = words_r[0] ^ (words_r[0] << 11);
  assign xs_w = words_r[3] ^ (words_r[3] >> 19) ^ xs_t ^ (xs_t >> 8);

  xs128_seed_mul u_mul (
    .clk   (clk),
    .issue (mul_issue),
    .x     (seed_r),
    .k     (k_r),
    .res   (mul_res)
  );

  xs128_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .word  (xs_w),
    .done  (norm_done),
    .bits  (norm_bits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    norm_start = 1'b0;
    mul_issue  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.operation == OP_SEED) begin
            state_nxt = ST_SEED_ISSUE;
          end else begin
            norm_start = 1'b1;
            state_nxt  = ST_NORM;
          end
        end
      end
      ST_SEED_ISSUE: begin
        mul_issue = 1'b1;
        state_nxt = ST_SEED_WAIT;
      end
      ST_SEED_WAIT: begin
        // chain ends after word 3 is written
        state_nxt = (k_r == 2'd3) ? ST_IDLE : ST_SEED_ISSUE;
      end
      ST_NORM: begin
        if (norm_done && out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state words and seed chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r[0] <= RST_WORD0;
      words_r[1] <= RST_WORD1;
      words_r[2] <= RST_WORD2;
      words_r[3] <= RST_WORD3;
      k_r        <= 2'd0;
    end else if (in_acc && in_data.operation == OP_DRAW) begin
      words_r[0] <= words_r[1];
      words_r[1] <= words_r[2];
      words_r[2] <= words_r[3];
      words_r[3] <= xs_w;
    end else if (in_acc) begin
      k_r <= 2'd0;
    end else if (state_r == ST_SEED_WAIT) begin
      words_r[k_r] <= mul_res;
      k_r          <= k_r + 2'd1;
    end
  end

  // seed chain value and raw word, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc && in_data.operation == OP_SEED) begin
      seed_r <= in_data.seed_value;
    end else if (state_r == ST_SEED_WAIT) begin
      seed_r <= mul_res;
    end
    if (in_acc && in_data.operation == OP_DRAW) begin
      raw_r <= xs_w;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.raw_word       <= raw_r;
      // zero word encodes as positive zero
      out_r.unit_real_bits <= (raw_r == 32'd0) ? 62'd0 : norm_bits;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### sv/xs128_checker.sv
// Port-level checker for the xorshift128 generator, bound to the top level.
// Depends on xs128_pkg and the assertion macro header.
`include "xorshift128_random_generator_core_macros.svh"

module xs128_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input xs128_pkg::out_word_t out_data
);
  import xs128_pkg::*;

  logic       in_acc;
  logic       out_held;
  logic       raw_zero;
  logic       real_zero;
  logic       top_set;
  logic [9:0] top_exp;

  assign in_acc    = in_valid && !in_stall;
  assign out_held  = out_valid && out_stall;
  assign raw_zero  = (out_data.raw_word == 32'd0);
  assign real_zero = (out_data.unit_real_bits == 62'd0);
  assign top_set   = out_valid && out_data.raw_word[31];
  assign top_exp   = out_data.unit_real_bits[61:52];

  `XS_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled word moved")
  `XS_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall, "input taken twice in a row")
  `XS_ASSERT_IMP(a_zero_maps_zero, out_valid, raw_zero == real_zero, "zero word/real mismatch")
  `XS_ASSERT_IMP(a_top_exponent, top_set, top_exp == EXP_TOP, "wrong exponent for top bit")

endmodule

bind xorshift128_random_generator_core xs128_checker u_xs128_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
